>>> src/two_button_hold_gesture_detector_top_defines.svh
// Assertion macros for the two-button hold gesture detector
`ifndef TWO_BUTTON_HOLD_GESTURE_DETECTOR_TOP_DEFINES_SVH
`define TWO_BUTTON_HOLD_GESTURE_DETECTOR_TOP_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define TBHGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gesture detector check failed");

// check that cons holds in the cycle after ante
`define TBHGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gesture detector check failed");

`endif

>>> src/tbhgd_pkg.sv
// Shared constants and register codes for the two-button hold gesture detector
`default_nettype none

package tbhgd_pkg;

    localparam int TIME_WIDTH_DEF  = 48;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_WIDTH-1:0] MUTE_HOLD_RST   = 32'd3000000;
    localparam logic [CFG_WIDTH-1:0] FORGET_HOLD_RST = 32'd10000000;
    localparam logic [CFG_WIDTH-1:0] TAP_MIN_RST     = 32'd30000;
    localparam logic [CFG_WIDTH-1:0] TAP_MAX_RST     = 32'd1000000;
    localparam logic [CFG_WIDTH-1:0] OFF_HOLD_RST    = 32'd3000000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MUTE_HOLD   = 3'd0,
        CFG_FORGET_HOLD = 3'd1,
        CFG_TAP_MIN     = 3'd2,
        CFG_TAP_MAX     = 3'd3,
        CFG_OFF_HOLD    = 3'd4
    } cfg_index_t;

endpackage

`default_nettype wire

>>> src/two_button_hold_gesture_detector_top.sv
// Two-button hold gesture detector: poll register, gesture logic and result register
`default_nettype none

// Takes one button poll per cycle while not stalled and returns one result per poll: the
// poll is held in an input register, the elapsed-time subtracts and threshold compares run
// on the held poll against the gesture state, and the result lands in an output register.
// Throughput is one poll per cycle; both stages advance together whenever the result
// register is free or being taken. Threshold registers are written through the cfg channel,
// which never stalls; unknown indexes are dropped. Once power off is reached, every later
// result reports power_off alone until reset.
module two_button_hold_gesture_detector_top #(
    parameter int TIME_WIDTH = tbhgd_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [TIME_WIDTH-1:0]                now_us,
    input  wire logic                                 boot_pin_pressed,
    input  wire logic                                 bench_boot_pressed,
    input  wire logic                                 pwr_pin_pressed,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      toggle_mute,
    output logic                                      forget_controller,
    output logic                                      battery_tap,
    output logic                                      power_off,
    output logic                                      boot_active,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tbhgd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [tbhgd_pkg::CFG_WIDTH-1:0]      cfg_data
);

    // configuration
    logic [tbhgd_pkg::CFG_WIDTH-1:0] mute_hold_reg;
    logic [tbhgd_pkg::CFG_WIDTH-1:0] forget_hold_reg;
    logic [tbhgd_pkg::CFG_WIDTH-1:0] tap_min_reg;
    logic [tbhgd_pkg::CFG_WIDTH-1:0] tap_max_reg;
    logic [tbhgd_pkg::CFG_WIDTH-1:0] off_hold_reg;

    // input register
    logic                  req_valid_reg;
    logic [TIME_WIDTH-1:0] req_now_reg;
    logic                  req_a_reg;
    logic                  req_b_reg;

    // gesture state
    logic                  boot_armed_reg, boot_armed_next;
    logic                  pwr_armed_reg, pwr_armed_next;
    logic                  boot_timing_reg, boot_timing_next;
    logic [TIME_WIDTH-1:0] boot_start_reg, boot_start_next;
    logic                  mute_done_reg, mute_done_next;
    logic                  forget_done_reg, forget_done_next;
    logic                  pwr_timing_reg, pwr_timing_next;
    logic [TIME_WIDTH-1:0] pwr_start_reg, pwr_start_next;
    logic                  halted_reg, halted_next;

    // result register
    logic out_valid_reg;
    logic mute_reg, mute_next;
    logic forget_reg, forget_next;
    logic tap_reg, tap_next;
    logic off_reg;
    logic active_reg, active_next;

    logic                  advance;
    logic                  a_hit;
    logic                  b_hit;
    logic [TIME_WIDTH-1:0] boot_base;
    logic [TIME_WIDTH-1:0] pwr_base;
    logic [TIME_WIDTH-1:0] boot_elapsed;
    logic [TIME_WIDTH-1:0] pwr_elapsed;
    logic                  mute_prior;
    logic                  forget_prior;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !req_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid         = out_valid_reg;
    assign toggle_mute       = mute_reg;
    assign forget_controller = forget_reg;
    assign battery_tap       = tap_reg;
    assign power_off         = off_reg;
    assign boot_active       = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_hold_reg   <= tbhgd_pkg::MUTE_HOLD_RST;
            forget_hold_reg <= tbhgd_pkg::FORGET_HOLD_RST;
            tap_min_reg     <= tbhgd_pkg::TAP_MIN_RST;
            tap_max_reg     <= tbhgd_pkg::TAP_MAX_RST;
            off_hold_reg    <= tbhgd_pkg::OFF_HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tbhgd_pkg::cfg_index_t'(cfg_index))
                tbhgd_pkg::CFG_MUTE_HOLD:   mute_hold_reg   <= cfg_data;
                tbhgd_pkg::CFG_FORGET_HOLD: forget_hold_reg <= cfg_data;
                tbhgd_pkg::CFG_TAP_MIN:     tap_min_reg     <= cfg_data;
                tbhgd_pkg::CFG_TAP_MAX:     tap_max_reg     <= cfg_data;
                tbhgd_pkg::CFG_OFF_HOLD:    off_hold_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // hold the request until the gesture stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_now_reg <= now_us;
            req_a_reg   <= boot_pin_pressed | bench_boot_pressed;
            req_b_reg   <= pwr_pin_pressed;
        end
    end

    always_comb
    begin
        a_hit        = boot_armed_reg && req_a_reg;
        b_hit        = pwr_armed_reg && req_b_reg;
        boot_base    = boot_timing_reg ? boot_start_reg : req_now_reg;
        pwr_base     = pwr_timing_reg ? pwr_start_reg : req_now_reg;
        boot_elapsed = req_now_reg - boot_base;
        pwr_elapsed  = req_now_reg - pwr_base;
        mute_prior   = boot_timing_reg && mute_done_reg;
        forget_prior = boot_timing_reg && forget_done_reg;

        boot_armed_next  = boot_armed_reg;
        pwr_armed_next   = pwr_armed_reg;
        boot_timing_next = boot_timing_reg;
        boot_start_next  = boot_start_reg;
        mute_done_next   = mute_done_reg;
        forget_done_next = forget_done_reg;
        pwr_timing_next  = pwr_timing_reg;
        pwr_start_next   = pwr_start_reg;
        halted_next      = halted_reg;
        mute_next        = 1'b0;
        forget_next      = 1'b0;
        tap_next         = 1'b0;
        active_next      = 1'b0;

        if (!halted_reg)
        begin
            boot_armed_next = boot_armed_reg || !req_a_reg;
            pwr_armed_next  = pwr_armed_reg || !req_b_reg;
            active_next     = a_hit;

            if (a_hit)
            begin
                boot_timing_next = 1'b1;
                boot_start_next  = boot_base;
                mute_next        = !mute_prior &&
                                   (boot_elapsed >= TIME_WIDTH'(mute_hold_reg));
                forget_next      = !forget_prior &&
                                   (boot_elapsed >= TIME_WIDTH'(forget_hold_reg));
                mute_done_next   = mute_prior || mute_next;
                forget_done_next = forget_prior || forget_next;
            end
            else
            begin
                boot_timing_next = 1'b0;
            end

            if (b_hit)
            begin
                pwr_timing_next = 1'b1;
                pwr_start_next  = pwr_base;
                halted_next     = pwr_elapsed >= TIME_WIDTH'(off_hold_reg);
            end
            else if (pwr_timing_reg)
            begin
                tap_next        = (pwr_elapsed > TIME_WIDTH'(tap_min_reg)) &&
                                  (pwr_elapsed < TIME_WIDTH'(tap_max_reg));
                pwr_timing_next = 1'b0;
            end
        end
    end

    // advance state and result together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_armed_reg  <= 1'b0;
            pwr_armed_reg   <= 1'b0;
            boot_timing_reg <= 1'b0;
            boot_start_reg  <= '0;
            mute_done_reg   <= 1'b0;
            forget_done_reg <= 1'b0;
            pwr_timing_reg  <= 1'b0;
            pwr_start_reg   <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= req_valid_reg;
            if (req_valid_reg)
            begin
                boot_armed_reg  <= boot_armed_next;
                pwr_armed_reg   <= pwr_armed_next;
                boot_timing_reg <= boot_timing_next;
                boot_start_reg  <= boot_start_next;
                mute_done_reg   <= mute_done_next;
                forget_done_reg <= forget_done_next;
                pwr_timing_reg  <= pwr_timing_next;
                pwr_start_reg   <= pwr_start_next;
                halted_reg      <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && req_valid_reg)
        begin
            mute_reg   <= mute_next;
            forget_reg <= forget_next;
            tap_reg    <= tap_next;
            off_reg    <= halted_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

>>> src/tbhgd_checker.sv
// Port-level checks for the two-button hold gesture detector, bound to the top level
`default_nettype none

`include "two_button_hold_gesture_detector_top_defines.svh"

module tbhgd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic toggle_mute,
    input wire logic forget_controller,
    input wire logic battery_tap,
    input wire logic power_off,
    input wire logic boot_active
);

    logic       off_seen_reg;
    logic [4:0] result_bits;
    logic       boot_pulse;
    logic       any_pulse;

    assign result_bits = {toggle_mute, forget_controller, battery_tap, power_off, boot_active};
    assign boot_pulse  = toggle_mute || forget_controller;
    assign any_pulse   = boot_pulse || battery_tap || boot_active;

    // mark once a delivered result has reported power off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && power_off)
        begin
            off_seen_reg <= 1'b1;
        end
    end

    `TBHGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bits))
    `TBHGD_ASSERT_NOW(a_off_frozen, out_valid && off_seen_reg, power_off && !any_pulse)
    `TBHGD_ASSERT_NOW(a_boot_pulse_active, out_valid && boot_pulse, boot_active)
    `TBHGD_ASSERT_NOW(a_tap_not_off, out_valid && battery_tap, !power_off)
    `TBHGD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind two_button_hold_gesture_detector_top tbhgd_checker u_tbhgd_checker (.*);

`default_nettype wire
